// ===== sv/dgrc_pkg.sv =====
// Package for the gated diagonal recurrent cell: Q4.12 helpers and the
// elaboration-time builders of the sigmoid and tanh activation tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dgrc_pkg;

    localparam int unsigned ACT_ENTRIES_DEFAULT = 1024;
    localparam int unsigned ACT_IDX_BITS_MAX    = 12;

    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned EINV_Q30 = 64'd395007542;

    typedef enum logic {
        ACT_SIGMOID,
        ACT_TANH
    } t_act_kind;

    typedef logic signed [15:0] t_q412;

    // unsigned quotient by shift and subtract, elaboration time only
    function automatic longint unsigned f_udiv64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-y) for y >= 0, Q2.30 in and out
    function automatic longint unsigned f_exp_neg_q30(input longint unsigned y);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned r;
        n    = y >> 30;
        f    = y & (Q30_ONE - 64'd1);
        term = Q30_ONE;
        pos  = Q30_ONE;
        neg  = 64'd0;
        for (longint unsigned i = 1; i <= 24; i++) begin
            term = f_udiv64((term * f) >> 30, i);
            if (i[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = pos - neg;
        if (n > 64'd40) begin
            n = 64'd40;
        end
        for (longint unsigned i = 0; i < n; i++) begin
            r = (r * EINV_Q30) >> 30;
        end
        return r;
    endfunction

    function automatic longint unsigned f_sig_pos_q30(input longint unsigned y);
        longint unsigned e;
        e = f_exp_neg_q30(y);
        return f_udiv64(Q30_ONE * Q30_ONE, Q30_ONE + e);
    endfunction

    function automatic longint signed f_q30_to_q12(input longint unsigned v);
        return longint'((v + 64'd131072) >> 18);
    endfunction

    // one table entry, evaluated at the midpoint of its step
    function automatic logic signed [13:0] f_act_entry(input t_act_kind kind,
                                                        input int unsigned k,
                                                        input int unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned s;
        longint unsigned t;
        longint signed   q;
        logic            is_neg;
        lo     = (2 * longint'(k) + 1) * 8;
        hi     = 8 * longint'(n);
        is_neg = (lo < hi);
        mag    = is_neg ? (hi - lo) : (lo - hi);
        y      = f_udiv64(mag << 30, 64'(n));
        if (kind == ACT_SIGMOID) begin
            s = f_sig_pos_q30(y);
            q = is_neg ? f_q30_to_q12(Q30_ONE - s) : f_q30_to_q12(s);
        end else begin
            t = 2 * f_sig_pos_q30(2 * y) - Q30_ONE;
            q = is_neg ? -f_q30_to_q12(t) : f_q30_to_q12(t);
        end
        return q[13:0];
    endfunction

    // clamp to [-8, 8) and scale to a table index
    function automatic logic [ACT_IDX_BITS_MAX-1:0] f_tab_index(input logic signed [16:0] x,
                                                                input int unsigned n);
        logic signed [16:0] xc;
        logic [15:0]        u;
        logic [28:0]        p;
        if (x < -17'sd32768) begin
            xc = -17'sd32768;
        end else if (x > 17'sd32767) begin
            xc = 17'sd32767;
        end else begin
            xc = x;
        end
        u = {~xc[15], xc[14:0]};
        p = {13'd0, u} * 29'(n);
        return p[27:16];
    endfunction

    function automatic t_q412 f_sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7fff;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/diagonal_gated_recurrent_cell_forward.sv =====
// Top level of the gated diagonal recurrent cell forward step: ten-stage
// pipeline over Q4.12 elements. Depends on dgrc_pkg and dgrc_act_rom.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | i_valid / o_ready  | i_gate_logit i_input_proj i_hidden_prev
//           |                    | i_diag_weight i_gate_bias i_cand_bias
//   output  | o_valid / i_ready  | o_hidden_new o_gated_out o_gate_value
//           |                    | o_cand_preact
//
// One transaction per cycle sustained while the output is taken; the path to
// the outputs runs through a chain of three table reads and five multiplies.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output freezes every stage, so o_ready is low only while the
// output holds an untaken transaction.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_gated_recurrent_cell_forward #(
    parameter int unsigned ACT_TABLE_ENTRIES = dgrc_pkg::ACT_ENTRIES_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire dgrc_pkg::t_q412 i_gate_logit,
    input  wire dgrc_pkg::t_q412 i_input_proj,
    input  wire dgrc_pkg::t_q412 i_hidden_prev,
    input  wire dgrc_pkg::t_q412 i_diag_weight,
    input  wire dgrc_pkg::t_q412 i_gate_bias,
    input  wire dgrc_pkg::t_q412 i_cand_bias,
    output logic                o_valid,
    input  wire logic           i_ready,
    output dgrc_pkg::t_q412     o_hidden_new,
    output dgrc_pkg::t_q412     o_gated_out,
    output logic [12:0]         o_gate_value,
    output dgrc_pkg::t_q412     o_cand_preact
);
    import dgrc_pkg::*;

    localparam int unsigned IW     = $clog2(ACT_TABLE_ENTRIES);
    localparam int unsigned STAGES = 10;

    logic               w_en;
    logic [STAGES-1:0]  r_vld;

    // stage 1
    logic [IW-1:0]      r1_gidx;
    logic signed [31:0] r1_prod;
    logic signed [16:0] r1_pc;
    t_q412              r1_hp;
    // stage 2
    logic signed [13:0] w2_alpha;
    t_q412              r2_pre;
    t_q412              r2_hp;
    // stage 3
    logic [IW-1:0]      r3_tidx;
    logic [12:0]        r3_alpha;
    t_q412              r3_pre;
    t_q412              r3_hp;
    // stage 4
    logic signed [13:0] w4_v;
    logic [12:0]        r4_alpha;
    t_q412              r4_pre;
    t_q412              r4_hp;
    // stage 5
    logic signed [29:0] r5_m1;
    logic signed [27:0] r5_m2;
    logic [12:0]        r5_alpha;
    t_q412              r5_pre;
    // stage 6
    t_q412              r6_h;
    logic [12:0]        r6_alpha;
    t_q412              r6_pre;
    // stage 7
    logic [IW-1:0]      r7_hidx;
    logic [30:0]        r7_hh;
    t_q412              r7_h;
    logic [12:0]        r7_alpha;
    t_q412              r7_pre;
    // stage 8
    logic signed [13:0] w8_sg;
    logic [30:0]        r8_hh;
    t_q412              r8_h;
    logic [12:0]        r8_alpha;
    t_q412              r8_pre;
    // stage 9
    logic [43:0]        r9_p;
    t_q412              r9_h;
    logic [12:0]        r9_alpha;
    t_q412              r9_pre;
    // stage 10 (output register)
    t_q412              r10_h;
    t_q412              r10_o;
    logic [12:0]        r10_alpha;
    t_q412              r10_pre;

    logic signed [16:0] n1_gsum;
    logic [ACT_IDX_BITS_MAX-1:0] n1_gidx;
    logic signed [20:0] n2_prnd;
    logic signed [21:0] n2_sum;
    logic [ACT_IDX_BITS_MAX-1:0] n3_tidx;
    logic signed [30:0] n6_sum;
    logic signed [18:0] n6_rnd;
    logic [ACT_IDX_BITS_MAX-1:0] n7_hidx;
    logic [44:0]        n10_rnd;
    logic [20:0]        n10_o;

    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        n1_gsum = 17'(i_gate_logit) + 17'(i_gate_bias);
        n1_gidx = f_tab_index(n1_gsum, ACT_TABLE_ENTRIES);
        n2_prnd = 21'((33'(r1_prod) + 33'sd2048) >>> 12);
        n2_sum  = 22'(n2_prnd) + 22'(r1_pc);
        n3_tidx = f_tab_index(17'(r2_pre), ACT_TABLE_ENTRIES);
        n6_sum  = 31'(r5_m1) + 31'(r5_m2);
        n6_rnd  = 19'((n6_sum + 31'sd2048) >>> 12);
        n7_hidx = f_tab_index(17'(r6_h), ACT_TABLE_ENTRIES);
        n10_rnd = ({1'b0, r9_p} + 45'd8388608) >> 24;
        n10_o   = n10_rnd[20:0];
    end

    dgrc_act_rom #(.ENTRIES(ACT_TABLE_ENTRIES), .KIND(ACT_SIGMOID)) u_gate_rom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_addr (r1_gidx),
        .o_data (w2_alpha)
    );

    dgrc_act_rom #(.ENTRIES(ACT_TABLE_ENTRIES), .KIND(ACT_TANH)) u_tanh_rom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_addr (r3_tidx),
        .o_data (w4_v)
    );

    dgrc_act_rom #(.ENTRIES(ACT_TABLE_ENTRIES), .KIND(ACT_SIGMOID)) u_out_rom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_addr (r7_hidx),
        .o_data (w8_sg)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_gidx   <= n1_gidx[IW-1:0];
            r1_prod   <= i_diag_weight * i_hidden_prev;
            r1_pc     <= 17'(i_input_proj) + 17'(i_cand_bias);
            r1_hp     <= i_hidden_prev;

            r2_pre    <= f_sat16(24'(n2_sum));
            r2_hp     <= r1_hp;

            r3_tidx   <= n3_tidx[IW-1:0];
            r3_alpha  <= w2_alpha[12:0];
            r3_pre    <= r2_pre;
            r3_hp     <= r2_hp;

            r4_alpha  <= r3_alpha;
            r4_pre    <= r3_pre;
            r4_hp     <= r3_hp;

            r5_m1     <= $signed({1'b0, r4_alpha}) * r4_hp;
            r5_m2     <= (14'sd4096 - $signed({1'b0, r4_alpha})) * w4_v;
            r5_alpha  <= r4_alpha;
            r5_pre    <= r4_pre;

            r6_h      <= f_sat16(24'(n6_rnd));
            r6_alpha  <= r5_alpha;
            r6_pre    <= r5_pre;

            r7_hidx   <= n7_hidx[IW-1:0];
            r7_hh     <= 31'($unsigned(32'(r6_h * r6_h)));
            r7_h      <= r6_h;
            r7_alpha  <= r6_alpha;
            r7_pre    <= r6_pre;

            r8_hh     <= r7_hh;
            r8_h      <= r7_h;
            r8_alpha  <= r7_alpha;
            r8_pre    <= r7_pre;

            r9_p      <= {13'd0, r8_hh} * {31'd0, w8_sg[12:0]};
            r9_h      <= r8_h;
            r9_alpha  <= r8_alpha;
            r9_pre    <= r8_pre;

            r10_o     <= (n10_o > 21'd32767) ? 16'sh7fff : n10_o[15:0];
            r10_h     <= r9_h;
            r10_alpha <= r9_alpha;
            r10_pre   <= r9_pre;
        end
    end

    assign o_valid       = r_vld[STAGES-1];
    assign o_hidden_new  = r10_h;
    assign o_gated_out   = r10_o;
    assign o_gate_value  = r10_alpha;
    assign o_cand_preact = r10_pre;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_gate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gate_value <= 13'd4096))
        else $error("gate value above one");

    a_out_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_gated_out[15])
        else $error("gated output negative");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

endmodule

`default_nettype wire

// ===== sv/dgrc_act_rom.sv =====
// Activation lookup table (sigmoid or tanh) with registered read data.
// Contents are built at elaboration by dgrc_pkg::f_act_entry.
`timescale 1ns / 1ps
`default_nettype none

module dgrc_act_rom #(
    parameter int unsigned         ENTRIES = dgrc_pkg::ACT_ENTRIES_DEFAULT,
    parameter dgrc_pkg::t_act_kind KIND    = dgrc_pkg::ACT_SIGMOID
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_addr,
    output logic signed [13:0]              o_data
);
    import dgrc_pkg::*;

    logic signed [13:0] w_rom [ENTRIES];
    logic signed [13:0] r_data;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam logic signed [13:0] ENTRY = f_act_entry(KIND, k, ENTRIES);
        assign w_rom[k] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== bench/diagonal_gated_recurrent_cell_forward_tb.sv =====
// Self-checking bench for diagonal_gated_recurrent_cell_forward: a directed table, then
// random Q4.12 elements, checked against typed results or a fixed-point model in this file.
// Depends on dgrc_pkg and the DUT only.
`timescale 1ns / 1ps

module diagonal_gated_recurrent_cell_forward_tb;

    import dgrc_pkg::*;

    localparam int unsigned LUT_SIZE    = 1024;
    localparam int          LATENCY     = 10;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          ITEMS_PER_PHASE = 250;
    localparam int          IDLE_LIGHT  = 12;
    localparam int          IDLE_HEAVY  = 57;
    localparam int          DIRECTED_ROWS = 20;

    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

    typedef struct {
        t_q412       logit;
        t_q412       proj;
        t_q412       hprev;
        t_q412       diag;
        t_q412       gbias;
        t_q412       cbias;
        bit          typed;
        t_q412       hidden;
        t_q412       gated;
        logic [12:0] gate;
        t_q412       preact;
    } t_cell_row;

    typedef struct {
        t_q412       hidden;
        t_q412       gated;
        logic [12:0] gate;
        t_q412       preact;
    } t_cell_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_q412       i_gate_logit = '0;
    t_q412       i_input_proj = '0;
    t_q412       i_hidden_prev = '0;
    t_q412       i_diag_weight = '0;
    t_q412       i_gate_bias = '0;
    t_q412       i_cand_bias = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_q412       o_hidden_new;
    t_q412       o_gated_out;
    logic [12:0] o_gate_value;
    t_q412       o_cand_preact;

    diagonal_gated_recurrent_cell_forward #(
        .ACT_TABLE_ENTRIES(LUT_SIZE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_gate_logit(i_gate_logit),
        .i_input_proj(i_input_proj),
        .i_hidden_prev(i_hidden_prev),
        .i_diag_weight(i_diag_weight),
        .i_gate_bias(i_gate_bias),
        .i_cand_bias(i_cand_bias),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_hidden_new(o_hidden_new),
        .o_gated_out(o_gated_out),
        .o_gate_value(o_gate_value),
        .o_cand_preact(o_cand_preact)
    );

    int           sigmoid_lut [LUT_SIZE];
    int           tanh_lut [LUT_SIZE];
    t_cell_result pending_cells [$];
    t_cell_row    stim_rows [DIRECTED_ROWS];
    int           error_count = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    logic         in_take = 1'b0;
    logic         out_take = 1'b0;
    t_cell_result seen;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // exp(-y), y >= 0, both Q2.30
    function automatic longint unsigned neg_exp_fixed(input longint unsigned y);
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned even_sum;
        longint unsigned odd_sum;
        longint unsigned r;
        whole    = y >> 30;
        frac     = y & (ONE_Q30 - 64'd1);
        term     = ONE_Q30;
        even_sum = ONE_Q30;
        odd_sum  = 64'd0;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * frac) >> 30) / 64'(i);
            if (i % 2 == 1) begin
                odd_sum += term;
            end else begin
                even_sum += term;
            end
        end
        r = even_sum - odd_sum;
        if (whole > 64'd40) begin
            whole = 64'd40;
        end
        for (longint unsigned j = 0; j < whole; j++) begin
            r = (r * EXP_M1_Q30) >> 30;
        end
        return r;
    endfunction

    function automatic longint unsigned logistic_q30(input longint unsigned y);
        return (ONE_Q30 * ONE_Q30) / (ONE_Q30 + neg_exp_fixed(y));
    endfunction

    function automatic int q30_round_q12(input longint unsigned v);
        return int'((v + 64'd131072) >> 18);
    endfunction

    task automatic build_activation_tables();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned s;
        int              tq;
        bit              below;
        for (int k = 0; k < LUT_SIZE; k++) begin
            lo    = (2 * longint'(k) + 1) * 8;
            hi    = 8 * longint'(LUT_SIZE);
            below = lo < hi;
            mag   = below ? hi - lo : lo - hi;
            y     = (mag << 30) / longint'(LUT_SIZE);
            s     = logistic_q30(y);
            tq    = q30_round_q12(2 * logistic_q30(2 * y) - ONE_Q30);
            sigmoid_lut[k] = below ? q30_round_q12(ONE_Q30 - s) : q30_round_q12(s);
            tanh_lut[k]    = below ? -tq : tq;
        end
    endtask

    function automatic int act_slot(input longint signed x);
        longint signed c;
        c = (x < -32768) ? -32768 : ((x > 32767) ? 32767 : x);
        return int'(((c + 32768) * longint'(LUT_SIZE)) >>> 16);
    endfunction

    function automatic longint signed q412_round(input longint signed v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint signed clamp_q412(input longint signed v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic t_cell_result cell_forward(input t_cell_row r);
        t_cell_result res;
        longint signed alpha;
        longint signed pre;
        longint signed cand;
        longint signed hid;
        longint signed sg;
        longint signed o;
        alpha = sigmoid_lut[act_slot(longint'(r.logit) + longint'(r.gbias))];
        pre   = clamp_q412(q412_round(longint'(r.diag) * longint'(r.hprev), 12)
                           + longint'(r.proj) + longint'(r.cbias));
        cand  = tanh_lut[act_slot(pre)];
        hid   = clamp_q412(q412_round(alpha * longint'(r.hprev) + (4096 - alpha) * cand, 12));
        sg    = sigmoid_lut[act_slot(hid)];
        o     = q412_round(hid * hid * sg, 24);
        if (o > 32767) begin
            o = 32767;
        end
        res.hidden = t_q412'(hid);
        res.gated  = t_q412'(o);
        res.gate   = 13'(alpha);
        res.preact = t_q412'(pre);
        return res;
    endfunction

    function automatic t_q412 draw_q412();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return t_q412'($urandom);
        end else if (pick < 85) begin
            return t_q412'(int'($urandom_range(16384)) - 8192);
        end
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic flag_error(input string line);
        if (error_count < 50) begin
            $display("%s", line);
        end
        error_count++;
    endtask

    // idle per cycle, hold each transaction until taken, then queue its prediction
    task automatic send_cell(input t_cell_row r);
        t_cell_result want;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_gate_logit  <= r.logit;
        i_input_proj  <= r.proj;
        i_hidden_prev <= r.hprev;
        i_diag_weight <= r.diag;
        i_gate_bias   <= r.gbias;
        i_cand_bias   <= r.cbias;
        do @(posedge i_clk); while (in_take !== 1'b1);
        if (r.typed) begin
            want.hidden = r.hidden;
            want.gated  = r.gated;
            want.gate   = r.gate;
            want.preact = r.preact;
        end else begin
            want = cell_forward(r);
        end
        pending_cells.push_back(want);
    endtask

    task automatic drain_pending();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // sample both handshakes mid-cycle, act on them at the next rising edge
    always @(negedge i_clk) begin
        in_take     <= i_rst_n && i_valid && o_ready;
        out_take    <= i_rst_n && o_valid && i_ready;
        seen.hidden <= o_hidden_new;
        seen.gated  <= o_gated_out;
        seen.gate   <= o_gate_value;
        seen.preact <= o_cand_preact;
    end

    always @(posedge i_clk) begin : check_outputs
        t_cell_result want;
        if (out_take === 1'b1) begin
            if (pending_cells.size() == 0) begin
                flag_error($sformatf("result %0d: output transaction with none pending",
                                     results_seen));
            end else begin
                want = pending_cells.pop_front();
                if (seen.hidden !== want.hidden)
                    flag_error($sformatf("result %0d hidden_new: got %0d expected %0d",
                                         results_seen, seen.hidden, want.hidden));
                if (seen.gated !== want.gated)
                    flag_error($sformatf("result %0d gated_out: got %0d expected %0d",
                                         results_seen, seen.gated, want.gated));
                if (seen.gate !== want.gate)
                    flag_error($sformatf("result %0d gate_value: got %0d expected %0d",
                                         results_seen, seen.gate, want.gate));
                if (seen.preact !== want.preact)
                    flag_error($sformatf("result %0d cand_preact: got %0d expected %0d",
                                         results_seen, seen.preact, want.preact));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_cell_row r;
        build_activation_tables();
        // logit, proj, hprev, diag, gbias, cbias, typed, hidden, gated, gate, preact
        stim_rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b1, 16'd16, 16'd0, 13'd2056, 16'd0},
            '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
              1'b1, 16'd32, 16'd0, 13'd1, 16'd0},
            '{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
              1'b1, 16'd0, 16'd0, 13'd4095, 16'd0},
            '{16'h0000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h7fff,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h8000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h7fff, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h0000, 16'h0001, 16'h0800, 16'h0000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h0000, 16'h0001, 16'hf800, 16'h0000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h4e20, 16'h1000, 16'h2000, 16'h1000, 16'h4e20, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'hffff, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'h0000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0},
            '{16'h0000, 16'h3000, 16'hf000, 16'h0000, 16'hc000, 16'h0000,
              1'b0, 16'd0, 16'd0, 13'd0, 16'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = IDLE_LIGHT;
        rx_idle_pct = IDLE_HEAVY;
        foreach (stim_rows[i]) begin
            send_cell(stim_rows[i]);
        end
        drain_pending();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? IDLE_LIGHT : ((phase == 1) ? IDLE_HEAVY : 0);
            rx_idle_pct = (phase == 0) ? IDLE_HEAVY : ((phase == 1) ? IDLE_LIGHT : 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r.logit = draw_q412();
                r.proj  = draw_q412();
                r.hprev = draw_q412();
                r.diag  = draw_q412();
                r.gbias = draw_q412();
                r.cbias = draw_q412();
                r.typed = 1'b0;
                send_cell(r);
            end
            drain_pending();
        end

        repeat (3 * LATENCY) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
